// ----- src/ialu_pkg.sv -----
`timescale 1ns / 1ps
package ialu_pkg;

	localparam int WORD_W = 32;

	typedef enum logic [3:0] {
		OP_NONE = 4'd0,
		OP_ADD  = 4'd1,
		OP_SUB  = 4'd2,
		OP_AND  = 4'd3,
		OP_OR   = 4'd4,
		OP_XOR  = 4'd5,
		OP_NOR  = 4'd6,
		OP_SLL  = 4'd7,
		OP_SRL  = 4'd8,
		OP_SRA  = 4'd9,
		OP_MULT = 4'd10,
		OP_DIV  = 4'd11,
		OP_SLT  = 4'd12
	} op_t;

	typedef enum logic [1:0] {
		CLS_SIMPLE = 2'd0,
		CLS_MULT   = 2'd1,
		CLS_DIV    = 2'd2
	} cls_t;

	// One classified transaction as it waits in the queue.
	typedef struct packed {
		cls_t              cls;
		logic              neg_q;
		logic              neg_r;
		logic              dz;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] a_mag;
		logic [WORD_W-1:0] b_mag;
	} item_t;

endpackage

// ----- src/ialu_front.sv -----
`timescale 1ns / 1ps
module ialu_front (
	input  logic [3:0]                 req_type,
	input  logic [ialu_pkg::WORD_W-1:0] src_a,
	input  logic [ialu_pkg::WORD_W-1:0] src_b,
	input  logic [4:0]                 shift_amount,
	output ialu_pkg::item_t            item
);
	import ialu_pkg::*;

	logic sa;
	logic sb;

	assign sa = src_a[WORD_W-1];
	assign sb = src_b[WORD_W-1];

	always_comb begin
		item.cls   = CLS_SIMPLE;
		item.lo    = '0;
		item.neg_q = sa ^ sb;
		item.neg_r = sa;
		item.dz    = (src_b == '0);
		item.a_mag = sa ? (~src_a + 1'b1) : src_a;
		item.b_mag = sb ? (~src_b + 1'b1) : src_b;
		unique case (req_type)
			OP_ADD:  item.lo = src_a + src_b;
			OP_SUB:  item.lo = src_a - src_b;
			OP_AND:  item.lo = src_a & src_b;
			OP_OR:   item.lo = src_a | src_b;
			OP_XOR:  item.lo = src_a ^ src_b;
			OP_NOR:  item.lo = ~(src_a | src_b);
			OP_SLL:  item.lo = src_b << shift_amount;
			OP_SRL:  item.lo = src_b >> shift_amount;
			OP_SRA:  item.lo = $unsigned($signed(src_b) >>> shift_amount);
			OP_MULT: item.cls = CLS_MULT;
			OP_DIV:  item.cls = CLS_DIV;
			OP_SLT:  item.lo = {{(WORD_W-1){1'b0}}, ($signed(src_a) < $signed(src_b))};
			default: item.lo = '0;
		endcase
	end

endmodule

// ----- src/ialu_fifo.sv -----
`timescale 1ns / 1ps
module ialu_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ialu_pkg::item_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output ialu_pkg::item_t pop_data
);
	import ialu_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	item_t       mem_q [DEPTH];
	logic [AW:0] wptr_q;
	logic [AW:0] rptr_q;

	// The top pointer bit flips on every wrap, so equal indexes mean full when it differs.
	assign full      = (wptr_q[AW] != rptr_q[AW]) && (wptr_q[AW-1:0] == rptr_q[AW-1:0]);
	assign not_empty = (wptr_q != rptr_q);
	assign pop_data  = mem_q[rptr_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q[AW-1:0]] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q[AW-1:0] == AW'(DEPTH-1)) ?
					{~wptr_q[AW], {AW{1'b0}}} : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q[AW-1:0] == AW'(DEPTH-1)) ?
					{~rptr_q[AW], {AW{1'b0}}} : rptr_q + 1'b1;
			end
		end
	end

endmodule

// ----- src/ialu_back.sv -----
`timescale 1ns / 1ps
module ialu_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  ialu_pkg::item_t             q_data,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ialu_pkg::WORD_W-1:0] result_low,
	output logic                        zero_flag,
	output logic [ialu_pkg::WORD_W-1:0] result_high,
	output logic                        writes_hi_lo
);
	import ialu_pkg::*;

	typedef struct packed {
		cls_t              cls;
		logic              neg_q;
		logic              neg_r;
		logic              dz;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] mb;
	} stage_t;

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	function automatic stage_t div_step(stage_t s);
		logic [WORD_W:0] r;
		stage_t          n;
		n = s;
		r = {s.hi, s.lo[WORD_W-1]};
		if (s.cls == CLS_DIV) begin
			n.lo = {s.lo[WORD_W-2:0], 1'b0};
			if (r >= {1'b0, s.mb}) begin
				r       = r - {1'b0, s.mb};
				n.lo[0] = 1'b1;
			end
			n.hi = r[WORD_W-1:0];
		end
		return n;
	endfunction

	stage_t              stg_s [WORD_W+1];
	logic [WORD_W:0]     vld_s;
	logic                out_valid_q;
	logic [WORD_W-1:0]   lo_q;
	logic [WORD_W-1:0]   hi_q;
	logic                hl_q;
	logic                en;
	stage_t              head;
	logic [2*WORD_W-1:0] prod;
	stage_t              tail;
	logic [2*WORD_W-1:0] prod_fix;
	logic [WORD_W-1:0]   lo_fix;
	logic [WORD_W-1:0]   hi_fix;

	assign en    = !out_valid_q || out_ready;
	assign q_pop = en && q_valid;
	assign prod  = (2*WORD_W)'(q_data.a_mag) * (2*WORD_W)'(q_data.b_mag);

	always_comb begin
		head.cls   = q_data.cls;
		head.neg_q = q_data.neg_q;
		head.neg_r = q_data.neg_r;
		head.dz    = q_data.dz;
		head.mb    = q_data.b_mag;
		case (q_data.cls)
			CLS_MULT: begin
				head.lo = prod[WORD_W-1:0];
				head.hi = prod[2*WORD_W-1:WORD_W];
			end
			CLS_DIV: begin
				head.lo = q_data.a_mag;
				head.hi = '0;
			end
			default: begin
				head.lo = q_data.lo;
				head.hi = '0;
			end
		endcase
	end

	assign tail     = stg_s[WORD_W];
	assign prod_fix = tail.neg_q ? (~{tail.hi, tail.lo} + 1'b1) : {tail.hi, tail.lo};

	always_comb begin
		case (tail.cls)
			CLS_MULT: begin
				lo_fix = prod_fix[WORD_W-1:0];
				hi_fix = prod_fix[2*WORD_W-1:WORD_W];
			end
			CLS_DIV: begin
				if (tail.dz) begin
					lo_fix = '0;
					hi_fix = '0;
				end else begin
					lo_fix = tail.neg_q ? (~tail.lo + 1'b1) : tail.lo;
					hi_fix = tail.neg_r ? (~tail.hi + 1'b1) : tail.hi;
				end
			end
			default: begin
				lo_fix = tail.lo;
				hi_fix = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0] <= head;
			for (int k = 0; k < WORD_W; k++) begin
				stg_s[k+1] <= div_step(stg_s[k]);
			end
			lo_q <= lo_fix;
			hi_q <= hi_fix;
			hl_q <= (tail.cls != CLS_SIMPLE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[WORD_W-1:0], q_valid};
			out_valid_q <= vld_s[WORD_W];
		end
	end

	assign out_valid    = out_valid_q;
	assign result_low   = lo_q;
	assign result_high  = hi_q;
	assign writes_hi_lo = hl_q;
	assign zero_flag    = (lo_q == '0);

endmodule

// ----- src/integer_alu_mul_div.sv -----
`timescale 1ns / 1ps
// 32-bit integer execution unit with add, subtract, logic, shifts, set-less-than,
// signed multiply into hi:lo and signed divide (quotient low, remainder high).
// A new transaction is accepted every cycle while the input queue has room.
// Every result takes the same path, whatever the operation: out of the queue
// through the multiplier into the first pipeline register, through the 32
// one-bit-per-stage divide stages, and through sign fix-up into the output
// register. Results leave in order. While out_valid is high and out_ready low
// the whole back pipeline holds, and the queue absorbs up to QUEUE_DEPTH more inputs.
module integer_alu_mul_div #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [3:0]                   req_type,
	input  logic [ialu_pkg::WORD_W-1:0]  src_a,
	input  logic [ialu_pkg::WORD_W-1:0]  src_b,
	input  logic [4:0]                   shift_amount,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ialu_pkg::WORD_W-1:0]  result_low,
	output logic                         zero_flag,
	output logic [ialu_pkg::WORD_W-1:0]  result_high,
	output logic                         writes_hi_lo
);
	import ialu_pkg::*;

	item_t item;
	item_t q_data;
	logic  full;
	logic  q_valid;
	logic  q_pop;

	assign in_ready = !full;

	ialu_front u_front (
		.req_type     (req_type),
		.src_a        (src_a),
		.src_b        (src_b),
		.shift_amount (shift_amount),
		.item         (item)
	);

	ialu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !full),
		.push_data (item),
		.full      (full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	ialu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_low   (result_low),
		.zero_flag    (zero_flag),
		.result_high  (result_high),
		.writes_hi_lo (writes_hi_lo)
	);

endmodule

// ----- src/ialu_checker.sv -----
`timescale 1ns / 1ps
module ialu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] result_low,
	input logic        zero_flag,
	input logic [31:0] result_high,
	input logic        writes_hi_lo
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_low) && $stable(result_high))
		else $error("stalled result changed");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> zero_flag == (result_low == 32'd0))
		else $error("zero flag disagrees with low result");

	a_hi_only_hilo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !writes_hi_lo |-> result_high == 32'd0)
		else $error("high result set on an operation that does not write hi/lo");

	a_stall_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(writes_hi_lo))
		else $error("hi/lo flag changed while stalled");

endmodule

bind integer_alu_mul_div ialu_checker u_ialu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_low   (result_low),
	.zero_flag    (zero_flag),
	.result_high  (result_high),
	.writes_hi_lo (writes_hi_lo)
);
